>>> rtl/swid_pkg.sv
// ----------------------------------------------------------------------------
// swid_pkg
// Shared types and constants for the mid/side stereo widener.
// ----------------------------------------------------------------------------
package swid_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_DEPTH = 1024;
  localparam int IDX_W       = $clog2(DELAY_DEPTH);
  localparam int LEN_W       = 11;
  localparam int COEF_W      = 24;
  localparam int Y_W         = 32;
  localparam int MEM_W       = Y_W;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 48;

  localparam logic [MODE_W-1:0]     MODE_RST   = 2'd0;
  localparam logic [COEF_W-1:0]     MASTER_RST = 24'd1048576;
  localparam logic [COEF_W-1:0]     CENTER_RST = 24'd1048576;
  localparam logic [COEF_W-1:0]     CROSS_RST  = 24'd1857715;
  localparam logic [COEF_W-1:0]     SELF_RST   = 24'd0;
  localparam logic [3*LEN_W-1:0]    DLEN_RST   = 33'd4640937;
  localparam logic [COEF_W-1:0]     HPF_G_RST  = 24'd4152260;
  localparam logic [2*COEF_W-1:0]   HPF_FB_RST = 48'd139319574611664;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_MASTER,
    REG_CENTER,
    REG_CROSS,
    REG_SELF,
    REG_DLEN,
    REG_HPF_G,
    REG_HPF_FB
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LINE_L,
    LINE_R,
    LINE_M
  } line_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          clipped;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0] mid;
    logic [LEN_W-1:0] right;
    logic [LEN_W-1:0] left;
  } len_t;

  typedef struct packed {
    logic             rd_en;
    line_e            rd_line;
    logic             wr_en;
    line_e            wr_line;
    logic [MEM_W-1:0] wr_data;
  } mem_req_t;

endpackage

>>> rtl/swid_delay_mem.sv
// ----------------------------------------------------------------------------
// swid_delay_mem
// Shared RAM for the left side, right side and mid delay lines, with the
// circular write index and fill count of each line.
// ----------------------------------------------------------------------------
module swid_delay_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swid_pkg::mem_req_t          req_i,
  input  swid_pkg::len_t              len_i,
  output logic [swid_pkg::MEM_W-1:0]  rd_data_o
);
  import swid_pkg::*;

  localparam int ADDR_W    = IDX_W + 2;
  localparam int MEM_DEPTH = 3 * (2 ** IDX_W);
  localparam int CNT_W     = IDX_W + 1;
  localparam int CMP_W     = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  logic [MEM_W-1:0] ram_q [MEM_DEPTH];
  logic [MEM_W-1:0] rd_raw_q;
  logic             rd_ok_q;

  logic [IDX_W-1:0] idx_l_q, idx_r_q, idx_m_q;
  logic [CNT_W-1:0] fill_l_q, fill_r_q, fill_m_q;

  logic [IDX_W-1:0]  rd_idx, wr_idx, wr_next;
  logic [CNT_W-1:0]  rd_fill, wr_fill, wr_inc;
  logic [LEN_W-1:0]  wr_len;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_wrap, wr_grow;

  always_comb begin
    rd_idx  = '0;
    rd_fill = '0;
    case (req_i.rd_line)
      LINE_L: begin
        rd_idx  = idx_l_q;
        rd_fill = fill_l_q;
      end
      LINE_R: begin
        rd_idx  = idx_r_q;
        rd_fill = fill_r_q;
      end
      LINE_M: begin
        rd_idx  = idx_m_q;
        rd_fill = fill_m_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_idx  = '0;
    wr_fill = '0;
    wr_len  = '0;
    case (req_i.wr_line)
      LINE_L: begin
        wr_idx  = idx_l_q;
        wr_fill = fill_l_q;
        wr_len  = len_i.left;
      end
      LINE_R: begin
        wr_idx  = idx_r_q;
        wr_fill = fill_r_q;
        wr_len  = len_i.right;
      end
      LINE_M: begin
        wr_idx  = idx_m_q;
        wr_fill = fill_m_q;
        wr_len  = len_i.mid;
      end
      default: ;
    endcase
  end

  assign rd_addr = {req_i.rd_line, rd_idx};
  assign wr_addr = {req_i.wr_line, wr_idx};
  assign wr_inc  = CNT_W'(wr_idx) + 1'b1;
  assign wr_wrap = (CMP_W'(wr_inc) >= CMP_W'(wr_len)) || (wr_inc >= CNT_W'(DELAY_DEPTH));
  assign wr_next = wr_wrap ? '0 : wr_inc[IDX_W-1:0];
  assign wr_grow = (CNT_W'(wr_idx) == wr_fill);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_l_q  <= '0;
      idx_r_q  <= '0;
      idx_m_q  <= '0;
      fill_l_q <= '0;
      fill_r_q <= '0;
      fill_m_q <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_ok_q <= (CNT_W'(rd_idx) < rd_fill);
      end
      if (req_i.wr_en) begin
        case (req_i.wr_line)
          LINE_L: begin
            idx_l_q <= wr_next;
            if (wr_grow) fill_l_q <= wr_fill + 1'b1;
          end
          LINE_R: begin
            idx_r_q <= wr_next;
            if (wr_grow) fill_r_q <= wr_fill + 1'b1;
          end
          LINE_M: begin
            idx_m_q <= wr_next;
            if (wr_grow) fill_m_q <= wr_fill + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      ram_q[wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= ram_q[rd_addr];
    end
  end

  // entries never written since reset read as zero
  assign rd_data_o = rd_ok_q ? rd_raw_q : '0;

`ifndef SYNTHESIS
  a_no_rw_same_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.rd_en && req_i.wr_en && req_i.rd_line == req_i.wr_line))
    else $error("read and write on the same delay line in one cycle");

  a_idx_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(idx_l_q) <= fill_l_q)
    else $error("left index ahead of its fill count");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.wr_en && req_i.wr_line == LINE_L) |=>
      (idx_l_q == '0 || idx_l_q == $past(idx_l_q) + 1'b1))
    else $error("left index did not advance or wrap");
`endif

endmodule

>>> rtl/stereo_widener_top.sv
// ----------------------------------------------------------------------------
// stereo_widener_top
// Mid/side stereo widener with highpass crossfeed on the side signals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one request carries a left/right sample pair and is taken
//   when in_valid_i is high and in_stall_o is low. Output channel: one
//   request per pair with both samples and a clip flag, taken when
//   out_valid_o is high and out_stall_i is low.
//   Sequencing: each pair steps through PREP, MUL, ACC, MIX, SUM, GAIN and FIN
//   before its result is registered; a new pair is taken only in idle, as
//   the sequencer walks each pair through the shared six-lane multiplier bank
//   and the single read port of the delay RAM.
//   A finished result waits in the output register while the next pair is
//   taken; if it is still stalled when the next result is ready, the
//   sequencer holds in its last step until the output register frees.
//   Configuration: writes on the cfg channel are always ready and take
//   effect at once; issue them only while no pair is in flight.
//   Reset: the configuration and control registers take their default values, filter history clears,
//   and every delay line reads as zero until its entries are written again;
//   there is no clearing pass.
// ----------------------------------------------------------------------------
module stereo_widener_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  swid_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output swid_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [swid_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import swid_pkg::*;

  localparam int LANES      = 6;
  localparam int SIDE_W     = SAMPLE_BITS + 1;
  localparam int DIFF_W     = SIDE_W + 2;
  localparam int MB_W       = (DIFF_W > Y_W) ? DIFF_W : Y_W;
  localparam int PROD_W     = COEF_W + MB_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int MIX_W      = PROD_W + 3;
  localparam int HPF_SHIFT  = 22;
  localparam int MIX_SHIFT  = 20;
  localparam int OUT_SHIFT  = 20;
  localparam int T_LIM_EXP  = 38;
  localparam int T_W        = T_LIM_EXP + 2;
  localparam int G_W        = T_W + COEF_W;

  localparam logic signed [ACC_W-1:0] HPF_HALF   = ACC_W'(1) << (HPF_SHIFT - 1);
  localparam logic signed [MIX_W-1:0] MIX_HALF   = MIX_W'(1) << (MIX_SHIFT - 1);
  localparam logic signed [MIX_W-1:0] T_HI       = MIX_W'(1) << T_LIM_EXP;
  localparam logic signed [MIX_W-1:0] T_LO       = -T_HI;
  localparam logic signed [G_W-1:0]   OUT_HALF   = G_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [G_W-1:0]   OUT_HALF_M = G_W'(1) << OUT_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_ACC,
    S_MIX,
    S_SUM,
    S_GAIN,
    S_FIN
  } state_e;

  // configuration
  logic [MODE_W-1:0]          mode_q;
  logic signed [COEF_W-1:0]   master_q, center_q, cross_q, self_q, hpf_g_q;
  len_t                       dlen_q;
  logic [2*COEF_W-1:0]        hpf_fb_q;

  // control and output
  state_e state_q;
  logic   out_valid_q;
  out_t   out_data_q;

  // datapath
  logic signed [SAMPLE_BITS-1:0] l_q, r_q, mid_q, dm_q;
  logic signed [SIDE_W-1:0]      ls_q, rs_q;
  logic signed [SIDE_W-1:0]      x1l_q, x2l_q, x1r_q, x2r_q;
  logic signed [Y_W-1:0]         y1l_q, y2l_q, y1r_q, y2r_q;
  logic signed [DIFF_W-1:0]      diffl_q, diffr_q;
  logic signed [Y_W-1:0]         dl_q, dr_q, yl_q, yr_q;
  logic signed [T_W-1:0]         tl_q, tr_q;
  logic signed [G_W-1:0]         gl_q, gr_q;
  logic signed [PROD_W-1:0]      prod_q [LANES];

  logic signed [COEF_W-1:0] mul_a [LANES];
  logic signed [MB_W-1:0]   mul_b [LANES];

  logic signed [SIDE_W-1:0] sum_lr, mid_w, ls_w, rs_w;
  logic signed [COEF_W-1:0] a1, a0;
  logic signed [ACC_W-1:0]  hsum_l, hsum_r, hrnd_l, hrnd_r;
  logic signed [MIX_W-1:0]  inner_l, inner_r, irnd_l, irnd_r;
  logic signed [G_W-1:0]    ornd_l, ornd_r;
  logic                     fit_l, fit_r;
  logic                     in_accept, bypass, mono, mid_on;
  logic [MEM_W-1:0]         rd_data;
  mem_req_t                 mem_req;
  out_t                     fin_data;

  function automatic logic signed [Y_W-1:0] sat_y(logic signed [ACC_W-1:0] v);
    logic [ACC_W-Y_W:0] hi;
    hi = v[ACC_W-1:Y_W-1];
    if ((&hi) || !(|hi)) sat_y = v[Y_W-1:0];
    else sat_y = v[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
  endfunction

  function automatic logic signed [T_W-1:0] clamp_t(logic signed [MIX_W-1:0] v);
    if (v > T_HI) clamp_t = T_HI[T_W-1:0];
    else if (v < T_LO) clamp_t = T_LO[T_W-1:0];
    else clamp_t = v[T_W-1:0];
  endfunction

  function automatic logic fits_out(logic signed [G_W-1:0] v);
    logic [G_W-SAMPLE_BITS:0] hi;
    hi = v[G_W-1:SAMPLE_BITS-1];
    fits_out = (&hi) || !(|hi);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(logic signed [G_W-1:0] v);
    if (fits_out(v)) sat_out = v[SAMPLE_BITS-1:0];
    else sat_out = v[G_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                            : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign bypass = mode_q[0];
  assign mono   = mode_q[1];
  assign mid_on = (dlen_q.mid > LEN_W'(1));
  assign a1     = $signed(hpf_fb_q[2*COEF_W-1:COEF_W]);
  assign a0     = $signed(hpf_fb_q[COEF_W-1:0]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RST;
      master_q <= MASTER_RST;
      center_q <= CENTER_RST;
      cross_q  <= CROSS_RST;
      self_q   <= SELF_RST;
      dlen_q   <= DLEN_RST;
      hpf_g_q  <= HPF_G_RST;
      hpf_fb_q <= HPF_FB_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_MASTER: master_q <= cfg_data_i[COEF_W-1:0];
        REG_CENTER: center_q <= cfg_data_i[COEF_W-1:0];
        REG_CROSS:  cross_q  <= cfg_data_i[COEF_W-1:0];
        REG_SELF:   self_q   <= cfg_data_i[COEF_W-1:0];
        REG_DLEN:   dlen_q   <= cfg_data_i[3*LEN_W-1:0];
        REG_HPF_G:  hpf_g_q  <= cfg_data_i[COEF_W-1:0];
        REG_HPF_FB: hpf_fb_q <= cfg_data_i[2*COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // mid/side split
  assign sum_lr = SIDE_W'(in_data_i.left_in) + SIDE_W'(in_data_i.right_in);
  assign mid_w  = sum_lr >>> 1;
  assign ls_w   = SIDE_W'(in_data_i.left_in) - mid_w;
  assign rs_w   = SIDE_W'(in_data_i.right_in) - mid_w;

  // multiplier bank operands
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      mul_a[k] = '0;
      mul_b[k] = '0;
    end
    case (state_q)
      S_MUL: begin
        mul_a[0] = a1;       mul_b[0] = MB_W'(y1l_q);
        mul_a[1] = a0;       mul_b[1] = MB_W'(y2l_q);
        mul_a[2] = hpf_g_q;  mul_b[2] = MB_W'(diffl_q);
        mul_a[3] = a1;       mul_b[3] = MB_W'(y1r_q);
        mul_a[4] = a0;       mul_b[4] = MB_W'(y2r_q);
        mul_a[5] = hpf_g_q;  mul_b[5] = MB_W'(diffr_q);
      end
      S_MIX: begin
        mul_a[0] = center_q; mul_b[0] = MB_W'(dm_q);
        mul_a[1] = cross_q;  mul_b[1] = MB_W'(dr_q);
        mul_a[2] = self_q;   mul_b[2] = MB_W'(dl_q);
        mul_a[3] = cross_q;  mul_b[3] = MB_W'(dl_q);
        mul_a[4] = self_q;   mul_b[4] = MB_W'(dr_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      prod_q[k] <= mul_a[k] * mul_b[k];
    end
  end

  // filter sums
  assign hsum_l = ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2]);
  assign hsum_r = ACC_W'(prod_q[3]) + ACC_W'(prod_q[4]) + ACC_W'(prod_q[5]);
  assign hrnd_l = (hsum_l + HPF_HALF) >>> HPF_SHIFT;
  assign hrnd_r = (hsum_r + HPF_HALF) >>> HPF_SHIFT;

  // output mix
  assign inner_l = (MIX_W'(ls_q) <<< MIX_SHIFT) + MIX_W'(prod_q[0])
                 - (MIX_W'(prod_q[1]) + MIX_W'(prod_q[2]));
  assign inner_r = (MIX_W'(rs_q) <<< MIX_SHIFT) + MIX_W'(prod_q[0])
                 - (MIX_W'(prod_q[3]) + MIX_W'(prod_q[4]));
  assign irnd_l  = (inner_l + MIX_HALF) >>> MIX_SHIFT;
  assign irnd_r  = (inner_r + MIX_HALF) >>> MIX_SHIFT;

  // master gain rounding and saturation
  assign ornd_l = mono ? ((gl_q + OUT_HALF_M) >>> (OUT_SHIFT + 1))
                       : ((gl_q + OUT_HALF) >>> OUT_SHIFT);
  assign ornd_r = mono ? ((gr_q + OUT_HALF_M) >>> (OUT_SHIFT + 1))
                       : ((gr_q + OUT_HALF) >>> OUT_SHIFT);
  assign fit_l  = fits_out(ornd_l);
  assign fit_r  = fits_out(ornd_r);

  always_comb begin
    if (bypass) begin
      fin_data.left_out  = l_q;
      fin_data.right_out = mono ? '0 : r_q;
      fin_data.clipped   = 1'b0;
    end else begin
      fin_data.left_out  = sat_out(ornd_l);
      fin_data.right_out = sat_out(ornd_r);
      fin_data.clipped   = !fit_l || !fit_r;
    end
  end

  // filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1l_q <= '0;
      x2l_q <= '0;
      y1l_q <= '0;
      y2l_q <= '0;
      x1r_q <= '0;
      x2r_q <= '0;
      y1r_q <= '0;
      y2r_q <= '0;
    end else if (state_q == S_ACC) begin
      x2l_q <= x1l_q;
      x1l_q <= ls_q;
      y2l_q <= y1l_q;
      y1l_q <= sat_y(hrnd_l);
      x2r_q <= x1r_q;
      x1r_q <= rs_q;
      y2r_q <= y1r_q;
      y1r_q <= sat_y(hrnd_r);
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      l_q   <= in_data_i.left_in;
      r_q   <= in_data_i.right_in;
      mid_q <= mid_w[SAMPLE_BITS-1:0];
      ls_q  <= ls_w;
      rs_q  <= rs_w;
    end
    case (state_q)
      S_PREP: begin
        diffl_q <= DIFF_W'(ls_q) - (DIFF_W'(x1l_q) <<< 1) + DIFF_W'(x2l_q);
        diffr_q <= DIFF_W'(rs_q) - (DIFF_W'(x1r_q) <<< 1) + DIFF_W'(x2r_q);
        dl_q    <= $signed(rd_data);
      end
      S_MUL: begin
        dr_q <= $signed(rd_data);
      end
      S_ACC: begin
        dm_q <= mid_on ? $signed(rd_data[SAMPLE_BITS-1:0]) : mid_q;
        yl_q <= sat_y(hrnd_l);
        yr_q <= sat_y(hrnd_r);
      end
      S_SUM: begin
        tl_q <= clamp_t(irnd_l);
        tr_q <= clamp_t(irnd_r);
      end
      S_GAIN: begin
        gl_q <= tl_q * master_q;
        gr_q <= tr_q * master_q;
      end
      default: ;
    endcase
  end

  // delay RAM requests: read old entries first, write back later
  always_comb begin
    mem_req         = '0;
    mem_req.rd_line = LINE_L;
    mem_req.wr_line = LINE_L;
    case (state_q)
      S_IDLE: begin
        mem_req.rd_en   = in_accept;
        mem_req.rd_line = LINE_L;
      end
      S_PREP: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_line = LINE_R;
      end
      S_MUL: begin
        mem_req.rd_en   = mid_on;
        mem_req.rd_line = LINE_M;
      end
      S_ACC: begin
        mem_req.wr_en   = mid_on;
        mem_req.wr_line = LINE_M;
        mem_req.wr_data = MEM_W'(mid_q);
      end
      S_MIX: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_line = LINE_L;
        mem_req.wr_data = yl_q;
      end
      S_SUM: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_line = LINE_R;
        mem_req.wr_data = yr_q;
      end
      default: ;
    endcase
  end

  swid_delay_mem u_delay_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .len_i     (dlen_q),
    .rd_data_o (rd_data)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_PREP;
        S_PREP: state_q <= S_MUL;
        S_MUL:  state_q <= S_ACC;
        S_ACC:  state_q <= S_MIX;
        S_MIX:  state_q <= S_SUM;
        S_SUM:  state_q <= S_GAIN;
        S_GAIN: state_q <= S_FIN;
        S_FIN: begin
          // hold until the output register frees
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= fin_data;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (state_q == S_ACC || state_q == S_MIX || state_q == S_SUM))
    else $error("delay write outside the write-back steps");

  a_bypass_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bypass) |-> !out_data_o.clipped)
    else $error("clip flag raised in bypass");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN && state_q == S_IDLE))
    else $error("output loaded outside the final step");
`endif

endmodule
